FILE: hdl/ata_pkg.sv
// shared constants, types and arctangent table for the tilt angle core
`timescale 1ns / 1ps
package ata_pkg;
   localparam int RAW_W = 12;
   localparam int CFG_W = 12;
   localparam int ANG_W = 15;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TAB_LEN = 24;
   localparam int PRESHIFT = 24;
   localparam int TERM_W = 26;
   localparam int DAT_W = 52;
   localparam int ACC_W = 32;
   localparam int XK_W = 50;
   localparam int CSR_IDX_W = 2;
   localparam logic [33:0] GAIN_Q32 = 34'd7072781453;
   // fraction part of the gain, the integer part is one
   localparam logic [31:0] GAIN_FRAC_Q32 = 32'd2777814157;
   localparam logic [11:0] MV_FULL = 12'd3300;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_G_X = 2'd0,
      CSR_ZERO_G_Y = 2'd1,
      CSR_ZERO_G_Z = 2'd2,
      CSR_ONE_G    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic roll_fix;
      logic pitch_fix;
      logic signed [ANG_W-1:0] roll_val;
      logic signed [ANG_W-1:0] pitch_val;
      logic undef;
      logic neg_x;
   } side_type;

   function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
      logic signed [ACC_W-1:0] t;
      begin
         t = '0;
         unique case (i)
            0: t = 32'sd294912000;  1: t = 32'sd174096719;
            2: t = 32'sd91987925;   3: t = 32'sd46694507;
            4: t = 32'sd23437865;   5: t = 32'sd11730358;
            6: t = 32'sd5866610;    7: t = 32'sd2933484;
            8: t = 32'sd1466764;    9: t = 32'sd733385;
            10: t = 32'sd366693;    11: t = 32'sd183346;
            12: t = 32'sd91673;     13: t = 32'sd45837;
            14: t = 32'sd22918;     15: t = 32'sd11459;
            16: t = 32'sd5730;      17: t = 32'sd2865;
            18: t = 32'sd1432;      19: t = 32'sd716;
            20: t = 32'sd358;       21: t = 32'sd179;
            22: t = 32'sd90;        23: t = 32'sd45;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

   function automatic logic signed [ANG_W-1:0] to_cdeg(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0] s;
      logic signed [ACC_W-16:0] r;
      begin
         s = {a[ACC_W-1], a} + (ACC_W+1)'(32768);
         r = s[ACC_W:16];
         if (r > 17'sd9000) r = 17'sd9000;
         if (r < -17'sd9000) r = -17'sd9000;
         return r[ANG_W-1:0];
      end
   endfunction
endpackage

FILE: hdl/ata_cordic_stage.sv
// one registered vectoring cordic iteration with stall control
`timescale 1ns / 1ps
module ata_cordic_stage import ata_pkg::*; #(
   parameter int STEP = 0,
   parameter int PASS_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic in_valid,
   input  logic signed [DAT_W-1:0] in_x,
   input  logic signed [DAT_W-1:0] in_y,
   input  logic signed [ACC_W-1:0] in_a,
   input  logic [PASS_W-1:0] in_pass,
   output logic out_valid,
   output logic signed [DAT_W-1:0] out_x,
   output logic signed [DAT_W-1:0] out_y,
   output logic signed [ACC_W-1:0] out_a,
   output logic [PASS_W-1:0] out_pass
);
   logic valid_ff;
   logic signed [DAT_W-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [ACC_W-1:0] a_ff, a_in;
   logic [PASS_W-1:0] pass_ff;

   always_comb begin
      if (!in_y[DAT_W-1]) begin
         x_in = in_x + (in_y >>> STEP);
         y_in = in_y - (in_x >>> STEP);
         a_in = in_a + atan_entry(STEP);
      end else begin
         x_in = in_x - (in_y >>> STEP);
         y_in = in_y + (in_x >>> STEP);
         a_in = in_a - atan_entry(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         a_ff <= a_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_a = a_ff;
   assign out_pass = pass_ff;
endmodule

FILE: hdl/ata_cordic_pipe.sv
// chain of cordic stages, one iteration per register stage
`timescale 1ns / 1ps
module ata_cordic_pipe import ata_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int PASS_W = 1
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic in_valid,
   input  logic signed [DAT_W-1:0] in_x,
   input  logic signed [DAT_W-1:0] in_y,
   input  logic [PASS_W-1:0] in_pass,
   output logic out_valid,
   output logic signed [DAT_W-1:0] out_x,
   output logic signed [ACC_W-1:0] out_a,
   output logic [PASS_W-1:0] out_pass
);
   localparam int N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
   logic v [N+1];
   logic signed [DAT_W-1:0] x [N+1];
   logic signed [DAT_W-1:0] y [N+1];
   logic signed [ACC_W-1:0] a [N+1];
   logic [PASS_W-1:0] p [N+1];

   assign v[0] = in_valid;
   assign x[0] = in_x;
   assign y[0] = in_y;
   assign a[0] = '0;
   assign p[0] = in_pass;

   for (genvar i = 0; i < N; i++) begin : g_stage
      ata_cordic_stage #(.STEP(i), .PASS_W(PASS_W)) u_stage (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(v[i]), .in_x(x[i]), .in_y(y[i]), .in_a(a[i]), .in_pass(p[i]),
         .out_valid(v[i+1]), .out_x(x[i+1]), .out_y(y[i+1]), .out_a(a[i+1]),
         .out_pass(p[i+1])
      );
   end

   assign out_valid = v[N];
   assign out_x = x[N];
   assign out_a = a[N];
   assign out_pass = p[N];
endmodule

FILE: hdl/ata_front.sv
// millivolt scaling, offset removal and operand preparation
`timescale 1ns / 1ps
module ata_front import ata_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic in_valid,
   input  logic [RAW_W-1:0] raw_x,
   input  logic [RAW_W-1:0] raw_y,
   input  logic [RAW_W-1:0] raw_z,
   input  logic [CFG_W-1:0] zero_g_x,
   input  logic [CFG_W-1:0] zero_g_y,
   input  logic [CFG_W-1:0] zero_g_z,
   input  logic [CFG_W-1:0] one_g,
   output logic out_valid,
   output logic signed [DAT_W-1:0] roll_x,
   output logic signed [DAT_W-1:0] roll_y,
   output logic signed [DAT_W-1:0] mag_x,
   output logic signed [DAT_W-1:0] mag_y,
   output logic [TERM_W-1:0] abs_x,
   output side_type side
);
   // stage 1: products and offsets
   logic v1_ff;
   logic [23:0] px_ff, py_ff, pz_ff;
   logic [12:0] ox_ff, oy_ff;
   logic signed [13:0] oz_ff;
   // stage 2: signed terms
   logic v2_ff;
   logic signed [TERM_W-1:0] ax_ff, ay_ff, az_ff;
   logic signed [TERM_W-1:0] ax_in, ay_in, az_in;
   // stage 3: operands
   logic v3_ff;
   logic signed [DAT_W-1:0] rx_ff, ry_ff, mx_ff, my_ff;
   logic [TERM_W-1:0] absx_ff;
   side_type side_ff, side_in;
   logic signed [TERM_W-1:0] zx, zy, my, mz, mxa;

   assign ax_in = TERM_W'(signed'({2'b0, px_ff})) - TERM_W'(signed'({1'b0, ox_ff, 12'b0}));
   assign ay_in = TERM_W'(signed'({2'b0, py_ff})) - TERM_W'(signed'({1'b0, oy_ff, 12'b0}));
   assign az_in = TERM_W'(signed'({2'b0, pz_ff})) - TERM_W'({oz_ff, 12'b0});

   always_comb begin
      zx = az_ff[TERM_W-1] ? -az_ff : az_ff;
      zy = az_ff[TERM_W-1] ? -ay_ff : ay_ff;
      my = ay_ff[TERM_W-1] ? -ay_ff : ay_ff;
      mz = zx;
      mxa = ax_ff[TERM_W-1] ? -ax_ff : ax_ff;
      side_in.roll_fix = (az_ff == '0);
      side_in.roll_val = (ay_ff == '0) ? '0 : (ay_ff[TERM_W-1] ? -15'sd9000 : 15'sd9000);
      side_in.pitch_fix = (ay_ff == '0) && (az_ff == '0);
      side_in.pitch_val = (ax_ff == '0) ? '0 : (ax_ff[TERM_W-1] ? -15'sd9000 : 15'sd9000);
      // zero over zero in roll, which also covers the pitch case
      side_in.undef = (az_ff == '0) && (ay_ff == '0);
      side_in.neg_x = ax_ff[TERM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (enable) begin
         px_ff <= raw_x * MV_FULL;
         py_ff <= raw_y * MV_FULL;
         pz_ff <= raw_z * MV_FULL;
         ox_ff <= {1'b0, zero_g_x};
         oy_ff <= {1'b0, zero_g_y};
         oz_ff <= signed'({2'b0, zero_g_z}) - signed'({2'b0, one_g});
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         az_ff <= az_in;
         rx_ff <= DAT_W'(zx) <<< PRESHIFT;
         ry_ff <= DAT_W'(zy) <<< PRESHIFT;
         mx_ff <= DAT_W'(mz) <<< PRESHIFT;
         my_ff <= DAT_W'(my) <<< PRESHIFT;
         absx_ff <= mxa;
         side_ff <= side_in;
      end
   end

   assign out_valid = v3_ff;
   assign roll_x = rx_ff;
   assign roll_y = ry_ff;
   assign mag_x = mx_ff;
   assign mag_y = my_ff;
   assign abs_x = absx_ff;
   assign side = side_ff;
endmodule

FILE: hdl/accel_tilt_angles_core.sv
// top level: tilt angle pipeline with output register
`timescale 1ns / 1ps
// Roll and pitch from one three-axis sample per cycle while the output is not
// stalled. A request is taken in every cycle that rsp_tready or the free output
// register allows; the path runs through 3 front stages, two cordic chains in
// series of CORDIC_STEPS stages each (at most TAB_LEN), 2 gain stages and 1 output
// stage. The pipeline advances as a whole only when its output register is empty
// or taken, so a result held there stalls every stage and blocks requests upstream.
module accel_tilt_angles_core import ata_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [39:0] req_tdata,   // raw_x, raw_y, raw_z, zero fill
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // roll_cdeg, pitch_cdeg, undefined, zero fill
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0] csr_data
);
   localparam int PASS_W = $bits(side_type) + TERM_W;
   localparam int PASS2_W = $bits(side_type) + ACC_W;

   logic [CFG_W-1:0] zgx_ff, zgy_ff, zgz_ff, oneg_ff;
   logic enable;
   logic f_valid;
   logic signed [DAT_W-1:0] rx, ry, mx, my;
   logic [TERM_W-1:0] absx;
   side_type f_side;

   logic r_valid, m_valid;
   logic signed [DAT_W-1:0] r_xo, m_xo;
   logic signed [ACC_W-1:0] r_ao, m_ao;
   logic [PASS_W-1:0] r_pass, m_pass;

   logic g1_valid_ff, g2_valid_ff;
   logic [57:0] gprod_ff;
   logic [TERM_W-1:0] gmx_ff;
   logic [59:0] gsum;
   logic signed [DAT_W-1:0] gr_ff, g2r_ff;
   logic signed [ACC_W-1:0] groll_ff, g2roll_ff;
   side_type gside_ff, g2side_ff;
   logic signed [DAT_W-1:0] xk_ff, xk_in;

   logic p_valid;
   logic signed [DAT_W-1:0] p_xo;
   logic signed [ACC_W-1:0] p_ao;
   logic [PASS2_W-1:0] p_pass;
   side_type p_side;
   logic signed [ACC_W-1:0] p_roll;

   logic o_valid_ff;
   logic [31:0] o_data_ff;
   logic signed [ANG_W-1:0] roll_o, pitch_o, pitch_c;

   assign enable = !o_valid_ff || rsp_tready;
   assign req_tready = enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zgx_ff <= 12'd1650;
         zgy_ff <= 12'd1650;
         zgz_ff <= 12'd1650;
         oneg_ff <= 12'd800;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ZERO_G_X: zgx_ff <= csr_data;
            CSR_ZERO_G_Y: zgy_ff <= csr_data;
            CSR_ZERO_G_Z: zgz_ff <= csr_data;
            CSR_ONE_G:    oneg_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ata_front u_front (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(req_tvalid && req_tready),
      .raw_x(req_tdata[11:0]), .raw_y(req_tdata[23:12]), .raw_z(req_tdata[35:24]),
      .zero_g_x(zgx_ff), .zero_g_y(zgy_ff), .zero_g_z(zgz_ff), .one_g(oneg_ff),
      .out_valid(f_valid), .roll_x(rx), .roll_y(ry), .mag_x(mx), .mag_y(my),
      .abs_x(absx), .side(f_side)
   );

   ata_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS), .PASS_W(PASS_W)) u_roll (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(f_valid),
      .in_x(rx), .in_y(ry), .in_pass({f_side, absx}),
      .out_valid(r_valid), .out_x(r_xo), .out_a(r_ao), .out_pass(r_pass)
   );

   ata_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS), .PASS_W(PASS_W)) u_mag (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(f_valid),
      .in_x(mx), .in_y(my), .in_pass({f_side, absx}),
      .out_valid(m_valid), .out_x(m_xo), .out_a(m_ao), .out_pass(m_pass)
   );

   // gain stage: |x| * K in Q32, shifted to the preshift scale
   assign gsum = 60'({gmx_ff, 32'b0}) + 60'(gprod_ff);
   assign xk_in = gsum[59:32-PRESHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (enable) begin
         g1_valid_ff <= m_valid;
         g2_valid_ff <= g1_valid_ff;
      end
      if (enable) begin
         gprod_ff <= 58'(m_pass[TERM_W-1:0]) * 58'(GAIN_FRAC_Q32);
         gmx_ff <= m_pass[TERM_W-1:0];
         gr_ff <= m_xo;
         groll_ff <= r_ao;
         gside_ff <= side_type'(r_pass[PASS_W-1:TERM_W]);
         xk_ff <= xk_in;
         g2r_ff <= gr_ff;
         g2roll_ff <= groll_ff;
         g2side_ff <= gside_ff;
      end
   end

   ata_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS), .PASS_W(PASS2_W)) u_pitch (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(g2_valid_ff),
      .in_x(g2r_ff), .in_y(xk_ff), .in_pass({g2side_ff, g2roll_ff}),
      .out_valid(p_valid), .out_x(p_xo), .out_a(p_ao), .out_pass(p_pass)
   );

   assign p_side = side_type'(p_pass[PASS2_W-1:ACC_W]);
   assign p_roll = p_pass[ACC_W-1:0];

   always_comb begin
      roll_o = p_side.roll_fix ? p_side.roll_val : to_cdeg(p_roll);
      pitch_c = to_cdeg(p_ao);
      pitch_o = p_side.pitch_fix ? p_side.pitch_val : (p_side.neg_x ? -pitch_c : pitch_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (enable) begin
         o_valid_ff <= p_valid;
      end
      if (enable) begin
         o_data_ff <= {1'b0, p_side.undef, pitch_o, roll_o};
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = o_data_ff;

   logic unused_ok;
   assign unused_ok = ^{r_valid, r_xo, m_ao, p_xo, r_pass[TERM_W-1:0],
                        m_pass[PASS_W-1:TERM_W], req_tdata[39:36]};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_sync: assert property (@(posedge clock) disable iff (reset) r_valid == m_valid)
      else $error("cordic lanes out of step");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[14:0]) <= 15'sd9000 &&
                     $signed(rsp_tdata[14:0]) >= -15'sd9000)
      else $error("roll out of range");
endmodule
